// ===== hdl/pwhd_pkg.sv =====
// Shared types, constants and helper functions for the peer wire
// handshake checker and message deframer. No dependencies.
package pwhd_pkg;

    // Bitfield store geometry
    localparam int BITFIELD_BYTES = 1024;
    localparam int ADDR_W         = $clog2(BITFIELD_BYTES);
    localparam int WCNT_W         = ADDR_W + 1;

    // Handshake layout
    localparam logic [6:0] HS_LAST       = 7'd67;
    localparam logic [6:0] HS_PROTO_LAST = 7'd19;
    localparam logic [6:0] HS_HASH_FIRST = 7'd28;
    localparam logic [6:0] HS_HASH_LAST  = 7'd47;
    localparam logic [7:0] HS_PSTRLEN    = 8'd19;
    localparam logic [151:0] PROTO_STR   = "BitTorrent protocol";

    // Message ids with special handling
    localparam logic [7:0] ID_UNCHOKE  = 8'd1;
    localparam logic [7:0] ID_BITFIELD = 8'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_HASH_0_7   = 2'd0;
    localparam logic [1:0] CFG_HASH_8_15  = 2'd1;
    localparam logic [1:0] CFG_HASH_16_19 = 2'd2;

    // Input opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_DISC = 2'd2;

    typedef enum logic [2:0] {
        EV_HS_OK     = 3'd0,
        EV_HS_FAIL   = 3'd1,
        EV_KEEPALIVE = 3'd2,
        EV_BF_DONE   = 3'd3,
        EV_UNCHOKE   = 3'd4,
        EV_OTHER     = 3'd5,
        EV_READ      = 3'd6,
        EV_DEAD      = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        PH_HANDSHAKE = 3'b001,
        PH_EST       = 3'b010,
        PH_DEAD      = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_READ = 2'd1,
        CMD_DISC = 2'd2
    } cmd_kind_t;

    // Classified item passed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [9:0] index;
    } cmd_t;

    // Push request and queue status passed from the front to the queue
    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

    // Byte k (0..18) of the protocol string
    function automatic logic [7:0] proto_byte(input logic [4:0] k);
        logic [7:0] sel;
        sel = PROTO_STR[8 * (18 - int'(k)) +: 8];
        return sel;
    endfunction

    // Byte k (0..19) of the expected content hash, byte 0 most significant
    function automatic logic [7:0] hash_byte(input logic [159:0] hash,
                                             input logic [4:0] k);
        logic [7:0] sel;
        sel = hash[8 * (19 - int'(k)) +: 8];
        return sel;
    endfunction

endpackage

// ===== hdl/pwhd_if.sv =====
// Channel interfaces for the peer wire deframer: received item channel
// and event channel. Depends on nothing.
interface pwhd_rx_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [9:0] read_index;

    modport source (output valid, opcode, rx_byte, read_index, input ready);
    modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

interface pwhd_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  frame_id;
    logic [31:0] message_length;
    logic [7:0]  read_data;
    logic        send_interested;
    logic        choked_flag;
    logic        bitfield_truncated;

    modport source (output valid, event_res, frame_id, message_length, read_data,
                    send_interested, choked_flag, bitfield_truncated, input ready);
    modport sink   (input valid, event_res, frame_id, message_length, read_data,
                    send_interested, choked_flag, bitfield_truncated, output ready);
endinterface

// ===== hdl/pwhd_front.sv =====
// Front end: accepts received items and classifies them into commands.
// Depends on pwhd_pkg and pwhd_rx_if.
module pwhd_front (
    pwhd_rx_if.sink          rx,
    input  logic             q_full,
    output pwhd_pkg::q_ctl_t q_ctl,
    output pwhd_pkg::cmd_t   cmd
);
    import pwhd_pkg::*;

    logic known_op;

    // Take an item whenever the queue has room
    assign rx.ready = !q_full;

    // Classify the opcode; drop unused codes here
    always_comb
    begin
        known_op   = 1'b1;
        cmd.data   = rx.rx_byte;
        cmd.index  = rx.read_index;
        cmd.kind   = CMD_BYTE;
        unique case (rx.opcode)
            OP_BYTE: cmd.kind = CMD_BYTE;
            OP_READ: cmd.kind = CMD_READ;
            OP_DISC: cmd.kind = CMD_DISC;
            default: known_op = 1'b0;
        endcase
    end

    assign q_ctl.push = rx.valid && !q_full && known_op;
    assign q_ctl.full = q_full;
endmodule

// ===== hdl/pwhd_queue.sv =====
// Two-entry command queue between front and back.
// Depends on pwhd_pkg.
module pwhd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  pwhd_pkg::q_ctl_t q_ctl,
    input  pwhd_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output pwhd_pkg::cmd_t   head
);
    import pwhd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = q_ctl.push && !q_ctl.full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end
endmodule

// ===== hdl/pwhd_back.sv =====
// Back end: handshake check, message deframing, bitfield store and the
// event output register. Depends on pwhd_pkg and pwhd_evt_if.
module pwhd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [159:0]     hash,
    input  logic             head_valid,
    input  pwhd_pkg::cmd_t   head,
    output logic             pop,
    pwhd_evt_if.source       evt
);
    import pwhd_pkg::*;

    // Connection state
    phase_t      phase_reg, phase_next;
    logic [6:0]  hs_pos_reg, hs_pos_next;
    logic        hs_bad_reg, hs_bad_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        in_body_reg, in_body_next;
    logic        id_byte_reg, id_byte_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic        ovf_reg, ovf_next;
    logic        int_sent_reg, int_sent_next;
    logic        choked_reg, choked_next;

    // Output stage
    logic        ovalid_reg, ovalid_next;
    event_t      oev_reg;
    logic [7:0]  oid_reg;
    logic [31:0] olen_reg;
    logic        osend_reg, ochoked_reg, otrunc_reg;
    logic        ord_reg, ord_ok_reg;

    // Result of the current command
    logic        res_valid;
    event_t      res_ev;
    logic [7:0]  res_id;
    logic [31:0] res_len;
    logic        res_send;
    logic        res_rd_ok;

    // Memory access
    logic [7:0]        mem [BITFIELD_BYTES];
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_q;

    logic        advance, fire;
    logic        hs_mis;
    logic [31:0] len_shift;
    logic [7:0]  id_now;
    logic [4:0]  proto_k, hash_k;

    assign advance = !ovalid_reg || evt.ready;
    assign pop     = advance;
    assign fire    = head_valid && advance;

    assign proto_k   = 5'(hs_pos_reg - 7'd1);
    assign hash_k    = 5'(hs_pos_reg - HS_HASH_FIRST);
    assign len_shift = {len_reg[23:0], head.data};
    assign id_now    = id_byte_reg ? head.data : cur_id_reg;
    assign rd_addr   = ADDR_W'(head.index);

    // Check one handshake byte against its expected value
    always_comb
    begin
        hs_mis = 1'b0;
        if (hs_pos_reg == 7'd0)
            hs_mis = (head.data != HS_PSTRLEN);
        else if (hs_pos_reg <= HS_PROTO_LAST)
            hs_mis = (head.data != proto_byte(proto_k));
        else if (hs_pos_reg >= HS_HASH_FIRST && hs_pos_reg <= HS_HASH_LAST)
            hs_mis = (head.data != hash_byte(hash, hash_k));
    end

    // Execute the command at the queue head
    always_comb
    begin
        phase_next    = phase_reg;
        hs_pos_next   = hs_pos_reg;
        hs_bad_next   = hs_bad_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        in_body_next  = in_body_reg;
        id_byte_next  = id_byte_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        cur_id_next   = cur_id_reg;
        wcnt_next     = wcnt_reg;
        ovf_next      = ovf_reg;
        int_sent_next = int_sent_reg;
        choked_next   = choked_reg;
        res_valid     = 1'b0;
        res_ev        = EV_OTHER;
        res_id        = 8'd0;
        res_len       = 32'd0;
        res_send      = 1'b0;
        res_rd_ok     = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        if (fire)
        begin
            unique case (head.kind)
                CMD_READ:
                begin
                    res_valid = 1'b1;
                    res_ev    = EV_READ;
                    rd_en     = 1'b1;
                    res_rd_ok = (32'(head.index) < 32'(BITFIELD_BYTES));
                end
                CMD_DISC:
                begin
                    res_valid  = 1'b1;
                    res_ev     = EV_DEAD;
                    phase_next = PH_DEAD;
                end
                CMD_BYTE:
                begin
                    unique case (phase_reg)
                        PH_HANDSHAKE:
                        begin
                            hs_bad_next = hs_bad_reg || hs_mis;
                            if (hs_pos_reg == HS_LAST)
                            begin
                                hs_pos_next = 7'd0;
                                res_valid   = 1'b1;
                                if (hs_bad_next)
                                begin
                                    phase_next = PH_DEAD;
                                    res_ev     = EV_HS_FAIL;
                                end
                                else
                                begin
                                    phase_next   = PH_EST;
                                    res_ev       = EV_HS_OK;
                                    hdr_cnt_next = 2'd0;
                                    in_body_next = 1'b0;
                                    len_next     = 32'd0;
                                end
                            end
                            else
                                hs_pos_next = hs_pos_reg + 7'd1;
                        end
                        PH_EST:
                        begin
                            if (!in_body_reg)
                            begin
                                // Collect the big-endian length
                                len_next     = len_shift;
                                hdr_cnt_next = hdr_cnt_reg + 2'd1;
                                if (hdr_cnt_reg == 2'd3)
                                begin
                                    if (len_shift == 32'd0)
                                    begin
                                        res_valid = 1'b1;
                                        res_ev    = EV_KEEPALIVE;
                                    end
                                    else
                                    begin
                                        in_body_next = 1'b1;
                                        id_byte_next = 1'b1;
                                        rem_next     = len_shift;
                                    end
                                end
                            end
                            else
                            begin
                                id_byte_next = 1'b0;
                                rem_next     = rem_reg - 32'd1;
                                if (id_byte_reg)
                                begin
                                    cur_id_next = head.data;
                                    wcnt_next   = '0;
                                    if (head.data == ID_BITFIELD)
                                        ovf_next = 1'b0;
                                end
                                else if (cur_id_reg == ID_BITFIELD)
                                begin
                                    // Store payload byte or drop it past capacity
                                    if (wcnt_reg < WCNT_W'(BITFIELD_BYTES))
                                    begin
                                        wr_en     = 1'b1;
                                        wcnt_next = wcnt_reg + WCNT_W'(1);
                                    end
                                    else
                                        ovf_next = 1'b1;
                                end
                                if (rem_reg == 32'd1)
                                begin
                                    in_body_next = 1'b0;
                                    hdr_cnt_next = 2'd0;
                                    len_next     = 32'd0;
                                    res_valid    = 1'b1;
                                    res_id       = id_now;
                                    res_len      = len_reg;
                                    if (id_now == ID_BITFIELD)
                                    begin
                                        res_ev        = EV_BF_DONE;
                                        res_send      = !int_sent_reg;
                                        int_sent_next = 1'b1;
                                    end
                                    else if (id_now == ID_UNCHOKE)
                                    begin
                                        res_ev      = EV_UNCHOKE;
                                        choked_next = 1'b0;
                                    end
                                    else
                                        res_ev = EV_OTHER;
                                end
                            end
                        end
                        PH_DEAD:
                        begin
                            res_valid = 1'b0;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Load or hold the output stage
    assign ovalid_next = advance ? res_valid : ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HANDSHAKE;
            hs_pos_reg   <= 7'd0;
            hs_bad_reg   <= 1'b0;
            hdr_cnt_reg  <= 2'd0;
            in_body_reg  <= 1'b0;
            id_byte_reg  <= 1'b0;
            len_reg      <= 32'd0;
            rem_reg      <= 32'd0;
            cur_id_reg   <= 8'd0;
            wcnt_reg     <= '0;
            ovf_reg      <= 1'b0;
            int_sent_reg <= 1'b0;
            choked_reg   <= 1'b1;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hs_pos_reg   <= hs_pos_next;
            hs_bad_reg   <= hs_bad_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            in_body_reg  <= in_body_next;
            id_byte_reg  <= id_byte_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            cur_id_reg   <= cur_id_next;
            wcnt_reg     <= wcnt_next;
            ovf_reg      <= ovf_next;
            int_sent_reg <= int_sent_next;
            choked_reg   <= choked_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            oev_reg     <= res_ev;
            oid_reg     <= res_id;
            olen_reg    <= res_len;
            osend_reg   <= res_send;
            ochoked_reg <= choked_next;
            otrunc_reg  <= ovf_next;
            ord_reg     <= rd_en;
            ord_ok_reg  <= res_rd_ok;
        end
    end

    // Bitfield store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wcnt_reg[ADDR_W-1:0]] <= head.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    assign evt.valid              = ovalid_reg;
    assign evt.event_res          = oev_reg;
    assign evt.frame_id           = oid_reg;
    assign evt.message_length     = olen_reg;
    assign evt.read_data          = (ord_reg && ord_ok_reg) ? rd_q : 8'd0;
    assign evt.send_interested    = osend_reg;
    assign evt.choked_flag        = ochoked_reg;
    assign evt.bitfield_truncated = otrunc_reg;
endmodule

// ===== hdl/peer_wire_handshake_and_deframer_top.sv =====
// Top level of the peer wire handshake checker and deframer.
// Depends on pwhd_pkg, pwhd_if, pwhd_front, pwhd_queue and pwhd_back.
//
// Usage:
//   rx_chan carries one item per handshake: a received stream byte, a
//   read of a stored bitfield byte, or a disconnect notice. evt_chan
//   returns at most one event per item. The expected 20-byte content
//   hash is written through cfg_we/cfg_index/cfg_data while idle.
//   An accepted item is registered in the queue, then executed by the
//   back end and any event it yields loaded into the output register;
//   a receiver stall holds it in the queue. Throughput: one item per
//   cycle unless the receiver stalls, since the back end executes the
//   queue head combinationally and has a one-write, one-read bitfield memory.
//   Reset: connection returns to handshaking, choked is set, the hash
//   registers clear. Bitfield store contents stay undefined until
//   written; there is no clearing pass.
//   Receiver stall: the output register holds its event, the back end
//   stops, and the two-entry queue fills; rx_chan.ready drops only when
//   the queue is full.
module peer_wire_handshake_and_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    pwhd_rx_if.sink     rx_chan,
    pwhd_evt_if.source  evt_chan,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import pwhd_pkg::*;

    logic [63:0] hash_hi_reg;
    logic [63:0] hash_mid_reg;
    logic [31:0] hash_lo_reg;

    q_ctl_t q_ctl;
    cmd_t   push_cmd;
    cmd_t   head;
    logic   q_full;
    logic   head_valid;
    logic   pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_hi_reg  <= 64'd0;
            hash_mid_reg <= 64'd0;
            hash_lo_reg  <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HASH_0_7:   hash_hi_reg  <= cfg_data;
                CFG_HASH_8_15:  hash_mid_reg <= cfg_data;
                CFG_HASH_16_19: hash_lo_reg  <= cfg_data[31:0];
                default:        hash_lo_reg  <= hash_lo_reg;
            endcase
        end
    end

    pwhd_front u_front (
        .rx     (rx_chan),
        .q_full (q_full),
        .q_ctl  (q_ctl),
        .cmd    (push_cmd)
    );

    pwhd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ctl      (q_ctl),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    pwhd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hash       ({hash_hi_reg, hash_mid_reg, hash_lo_reg}),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .evt        (evt_chan)
    );
endmodule
